@@ hw/rtl/epda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epda_pkg: shared types and constants of the echo pulse distance averager
// Field widths, register codes, reset values, controller state and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package epda_pkg;

    localparam int CAP_W      = 16;
    localparam int DIST_W     = 16;
    localparam int CFG_W      = 16;
    localparam int TALLY_W    = 8;
    localparam int SUM_W      = 20;
    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 4;
    // n * M + M + f stays below 2^25
    localparam int WIDTH_W    = 25;
    localparam int PROD_W     = WIDTH_W + CFG_W;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_CAPTURE = 1'b1;

    localparam logic [TALLY_W-1:0] TALLY_MAX    = '1;
    localparam logic               RST_AVG_EN   = 1'b1;
    localparam logic [CFG_W-1:0]   RST_MODULUS  = 16'hFFFF;
    localparam logic [CFG_W-1:0]   RST_SCALE    = 16'd1;
    localparam logic [CFG_W-1:0]   RST_MAX_DIST = 16'd450;
    localparam logic [IDX_W-1:0]   IDX_FIRST    = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AVG_EN   = 4'd0,
        REG_MODULUS  = 4'd1,
        REG_SCALE    = 4'd2,
        REG_MAX_DIST = 4'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIDTH,
        ST_SCALE,
        ST_CLAMP,
        ST_SUM,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic do_width;
        logic do_scale;
        logic do_clamp;
        logic do_sum;
        logic do_div;
        logic do_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic fall_capture;
        logic out_free;
    } t_dp_status;

endpackage

@@ hw/rtl/epda_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epda_in_if: event channel
// Timer overflow ticks and capture events with valid/ready handshake.
// ----------------------------------------------------------------------------
interface epda_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic                       channel;
    logic [epda_pkg::CAP_W-1:0] capture_value;

    modport source (output valid, cmd, channel, capture_value, input ready);
    modport sink   (input valid, cmd, channel, capture_value, output ready);
endinterface

@@ hw/rtl/epda_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epda_out_if: result channel
// One measurement result per falling edge with valid/ready handshake.
// ----------------------------------------------------------------------------
interface epda_out_if;
    logic                        valid;
    logic                        ready;
    logic                        source_channel;
    logic [epda_pkg::DIST_W-1:0] distance;
    logic                        report_valid;
    logic [epda_pkg::DIST_W-1:0] report_distance;
    logic                        trigger_next;

    modport source (output valid, source_channel, distance, report_valid,
                    report_distance, trigger_next, input ready);
    modport sink   (input valid, source_channel, distance, report_valid,
                    report_distance, trigger_next, output ready);
endinterface

@@ hw/rtl/epda_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epda_cfg_if: configuration write channel
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface epda_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [epda_pkg::CFG_IDX_W-1:0] index;
    logic [epda_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/epda_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epda_ctrl: sequencing controller
// Accepts events in idle and steps a falling-edge measurement through the
// width, scale, clamp, sum, divide and emit steps of the datapath.
// ----------------------------------------------------------------------------
module epda_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  epda_pkg::t_dp_status i_status,
    output epda_pkg::t_dp_cmd    o_cmd,
    output logic                 o_in_ready
);

    epda_pkg::t_state r_state;
    epda_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epda_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            epda_pkg::ST_IDLE: begin
                if (i_in_valid && i_status.fall_capture) begin
                    n_state = epda_pkg::ST_WIDTH;
                end
            end
            epda_pkg::ST_WIDTH: n_state = epda_pkg::ST_SCALE;
            epda_pkg::ST_SCALE: n_state = epda_pkg::ST_CLAMP;
            epda_pkg::ST_CLAMP: n_state = epda_pkg::ST_SUM;
            epda_pkg::ST_SUM:   n_state = epda_pkg::ST_DIV;
            epda_pkg::ST_DIV:   n_state = epda_pkg::ST_EMIT;
            epda_pkg::ST_EMIT: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    n_state = epda_pkg::ST_IDLE;
                end
            end
            default: n_state = epda_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            epda_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            epda_pkg::ST_WIDTH: o_cmd.do_width = 1'b1;
            epda_pkg::ST_SCALE: o_cmd.do_scale = 1'b1;
            epda_pkg::ST_CLAMP: o_cmd.do_clamp = 1'b1;
            epda_pkg::ST_SUM:   o_cmd.do_sum   = 1'b1;
            epda_pkg::ST_DIV:   o_cmd.do_div   = 1'b1;
            epda_pkg::ST_EMIT:  o_cmd.do_emit  = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ hw/rtl/epda_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epda_dp: measurement datapath
// Configuration registers, per-channel pulse state, width/scale/clamp
// arithmetic, averaging with a reciprocal divide and the output register.
// ----------------------------------------------------------------------------
module epda_dp #(
    parameter int AVG_COUNT    = 10,
    parameter int NUM_CHANNELS = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  epda_pkg::t_dp_cmd              i_cmd,
    output epda_pkg::t_dp_status           o_status,
    input  logic                           i_in_cmd,
    input  logic                           i_in_channel,
    input  logic [epda_pkg::CAP_W-1:0]     i_in_capture_value,
    input  logic                           i_cfg_valid,
    input  logic [epda_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [epda_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic                           o_out_source_channel,
    output logic [epda_pkg::DIST_W-1:0]    o_out_distance,
    output logic                           o_out_report_valid,
    output logic [epda_pkg::DIST_W-1:0]    o_out_report_distance,
    output logic                           o_out_trigger_next
);

    localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DIV_SHIFT   = epda_pkg::SUM_W + $clog2(AVG_COUNT);
    localparam int DIV_MULT_W  = epda_pkg::SUM_W + 1;
    localparam int QPROD_W     = epda_pkg::SUM_W + DIV_MULT_W;
    // ceil(2^(N+l) / d) gives an exact quotient for every N-bit dividend
    localparam logic [DIV_MULT_W-1:0] DIV_MULT =
        DIV_MULT_W'(((64'd1 << DIV_SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));
    localparam logic [epda_pkg::IDX_W-1:0] IDX_LAST = epda_pkg::IDX_W'(AVG_COUNT);
    localparam logic [2:0] NCH = 3'(NUM_CHANNELS);

    // configuration
    logic                       r_avg_en;
    logic [epda_pkg::CFG_W-1:0] r_modulus;
    logic [epda_pkg::CFG_W-1:0] r_scale;
    logic [epda_pkg::CFG_W-1:0] r_max_dist;

    // per-channel state
    logic                         r_await [NUM_CHANNELS];
    logic [epda_pkg::CAP_W-1:0]   r_rise  [NUM_CHANNELS];
    logic [epda_pkg::TALLY_W-1:0] r_tally [NUM_CHANNELS];
    logic [epda_pkg::SUM_W-1:0]   r_sum   [NUM_CHANNELS];
    logic [epda_pkg::IDX_W-1:0]   r_idx   [NUM_CHANNELS];

    // measurement in flight
    logic [CH_W-1:0]             r_ch;
    logic                        r_src;
    logic [epda_pkg::CAP_W-1:0]  r_fall;
    logic [epda_pkg::WIDTH_W-1:0] r_width;
    logic [epda_pkg::PROD_W-1:0] r_prod;
    logic [epda_pkg::DIST_W-1:0] r_dist;
    logic [epda_pkg::SUM_W-1:0]  r_sum_q;
    logic                        r_rep_due;
    logic [QPROD_W-1:0]          r_qprod;

    // output register
    logic                        r_out_valid;
    logic                        r_out_src;
    logic [epda_pkg::DIST_W-1:0] r_out_dist;
    logic                        r_out_rep_valid;
    logic [epda_pkg::DIST_W-1:0] r_out_rep;
    logic                        r_out_trig;

    logic                         w_ch_ok;
    logic [CH_W-1:0]              w_ch_idx;
    logic                         w_is_capture;
    logic                         w_fall;
    logic [epda_pkg::WIDTH_W-1:0] w_base;
    logic [epda_pkg::WIDTH_W-1:0] w_wrap;
    logic [epda_pkg::WIDTH_W-1:0] w_rise_x;
    logic [epda_pkg::WIDTH_W-1:0] w_fall_x;
    logic [epda_pkg::WIDTH_W-1:0] w_width;
    logic [epda_pkg::PROD_W-1:0]  w_prod;
    logic [epda_pkg::PROD_W-2:0]  w_half;
    logic [epda_pkg::SUM_W-1:0]   w_new_sum;
    logic [QPROD_W-1:0]           w_qprod;
    logic [epda_pkg::DIST_W-1:0]  w_quot;
    logic [epda_pkg::DIST_W-1:0]  w_rep;
    logic [2:0]                   w_next;
    logic                         w_trig;

    // ---------------- input decode ----------------
    assign w_ch_ok      = (NUM_CHANNELS > 1) || (i_in_channel == 1'b0);
    assign w_ch_idx     = CH_W'(i_in_channel);
    assign w_is_capture = (i_in_cmd == epda_pkg::CMD_CAPTURE) && w_ch_ok;
    assign w_fall       = w_is_capture && r_await[w_ch_idx];

    assign o_status.fall_capture = w_fall;
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    // ---------------- arithmetic ----------------
    assign w_base   = epda_pkg::WIDTH_W'(r_tally[r_ch]) * epda_pkg::WIDTH_W'(r_modulus);
    assign w_rise_x = epda_pkg::WIDTH_W'(r_rise[r_ch]);
    assign w_fall_x = epda_pkg::WIDTH_W'(r_fall);
    assign w_wrap   = epda_pkg::WIDTH_W'(r_modulus) + w_fall_x + w_base;

    always_comb begin
        if (w_fall_x >= w_rise_x) begin
            w_width = w_fall_x - w_rise_x + w_base;
        end else if (w_wrap < w_rise_x) begin
            // only a capture above the modulus gets here
            w_width = '0;
        end else begin
            w_width = w_wrap - w_rise_x;
        end
    end

    assign w_prod    = epda_pkg::PROD_W'(r_width) * epda_pkg::PROD_W'(r_scale);
    assign w_half    = r_prod[epda_pkg::PROD_W-1:1];
    assign w_new_sum = r_sum[r_ch] + epda_pkg::SUM_W'(r_dist);
    assign w_qprod   = QPROD_W'(r_sum_q) * QPROD_W'(DIV_MULT);
    assign w_quot    = r_qprod[DIV_SHIFT +: epda_pkg::DIST_W];

    always_comb begin
        if (!r_avg_en) begin
            w_rep = r_dist;
        end else if (r_rep_due) begin
            w_rep = w_quot;
        end else begin
            w_rep = '0;
        end
    end

    always_comb begin
        w_next = 3'(r_src) + 3'd1;
        if (w_next >= NCH) begin
            w_next = w_next - NCH;
        end
    end
    assign w_trig = w_next[0];

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_en   <= epda_pkg::RST_AVG_EN;
            r_modulus  <= epda_pkg::RST_MODULUS;
            r_scale    <= epda_pkg::RST_SCALE;
            r_max_dist <= epda_pkg::RST_MAX_DIST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                epda_pkg::REG_AVG_EN:   r_avg_en   <= i_cfg_data[0];
                epda_pkg::REG_MODULUS:  r_modulus  <= i_cfg_data;
                epda_pkg::REG_SCALE:    r_scale    <= i_cfg_data;
                epda_pkg::REG_MAX_DIST: r_max_dist <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- channel state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_await[i] <= 1'b0;
                r_rise[i]  <= '0;
                r_tally[i] <= '0;
                r_sum[i]   <= '0;
                r_idx[i]   <= epda_pkg::IDX_FIRST;
            end
        end else begin
            if (i_cmd.accept) begin
                if (i_in_cmd == epda_pkg::CMD_TICK) begin
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (r_tally[i] != epda_pkg::TALLY_MAX) begin
                            r_tally[i] <= r_tally[i] + 1'b1;
                        end
                    end
                end else if (w_is_capture) begin
                    if (r_await[w_ch_idx]) begin
                        r_await[w_ch_idx] <= 1'b0;
                    end else begin
                        r_await[w_ch_idx] <= 1'b1;
                        r_rise[w_ch_idx]  <= i_in_capture_value;
                        r_tally[w_ch_idx] <= '0;
                    end
                end
            end
            if (i_cmd.do_sum && r_avg_en) begin
                if (r_idx[r_ch] < IDX_LAST) begin
                    r_sum[r_ch] <= w_new_sum;
                    r_idx[r_ch] <= r_idx[r_ch] + 1'b1;
                end else begin
                    r_sum[r_ch] <= '0;
                    r_idx[r_ch] <= epda_pkg::IDX_FIRST;
                end
            end
        end
    end

    // ---------------- measurement steps ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_fall) begin
            r_ch   <= w_ch_idx;
            r_src  <= i_in_channel;
            r_fall <= i_in_capture_value;
        end
        if (i_cmd.do_width) begin
            r_width <= w_width;
        end
        if (i_cmd.do_scale) begin
            r_prod <= w_prod;
        end
        if (i_cmd.do_clamp) begin
            r_dist <= (w_half > (epda_pkg::PROD_W-1)'(r_max_dist)) ?
                      r_max_dist : w_half[epda_pkg::DIST_W-1:0];
        end
        if (i_cmd.do_sum) begin
            r_sum_q   <= w_new_sum;
            r_rep_due <= !r_avg_en || (r_idx[r_ch] >= IDX_LAST);
        end
        if (i_cmd.do_div) begin
            r_qprod <= w_qprod;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_emit) begin
            r_out_src       <= r_src;
            r_out_dist      <= r_dist;
            r_out_rep_valid <= r_rep_due;
            r_out_rep       <= w_rep;
            r_out_trig      <= w_trig;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_out_source_channel  = r_out_src;
    assign o_out_distance        = r_out_dist;
    assign o_out_report_valid    = r_out_rep_valid;
    assign o_out_report_distance = r_out_rep;
    assign o_out_trigger_next    = r_out_trig;

endmodule

@@ hw/rtl/echo_pulse_distance_averager.sv @@
`timescale 1ns / 1ps
// Timer ticks, rising-edge captures and ignored captures are taken in idle and leave the controller there.
// A falling-edge capture runs six sequencer steps (width, scale, clamp, sum,
// divide, emit): the emit step registers the result and returns to idle, where
// the next event is taken, so no event is accepted while a measurement runs.
// The emit step holds while the output register is still full.
// Synchronous active-low reset loads register defaults and resets all channel state.
// ----------------------------------------------------------------------------
// echo_pulse_distance_averager: two-channel ultrasonic echo ranging
// Times echo pulses from capture events, converts to a clamped distance
// and optionally averages a fixed number of distances per channel.
// ----------------------------------------------------------------------------
module echo_pulse_distance_averager #(
    parameter int AVG_COUNT    = 10,
    parameter int NUM_CHANNELS = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    epda_in_if.sink    i_in,
    epda_out_if.source o_out,
    epda_cfg_if.sink   i_cfg
);

    epda_pkg::t_dp_cmd    w_cmd;
    epda_pkg::t_dp_status w_status;

    assign i_cfg.ready = 1'b1;

    epda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (i_in.ready)
    );

    epda_dp #(
        .AVG_COUNT    (AVG_COUNT),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_status              (w_status),
        .i_in_cmd              (i_in.cmd),
        .i_in_channel          (i_in.channel),
        .i_in_capture_value    (i_in.capture_value),
        .i_cfg_valid           (i_cfg.valid),
        .i_cfg_index           (i_cfg.index),
        .i_cfg_data            (i_cfg.data),
        .i_out_ready           (o_out.ready),
        .o_out_valid           (o_out.valid),
        .o_out_source_channel  (o_out.source_channel),
        .o_out_distance        (o_out.distance),
        .o_out_report_valid    (o_out.report_valid),
        .o_out_report_distance (o_out.report_distance),
        .o_out_trigger_next    (o_out.trigger_next)
    );

endmodule

@@ hw/rtl/epda_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epda_checker: port-level assertions
// Watches the result and configuration channels of the top level.
// ----------------------------------------------------------------------------
module epda_checker #(
    parameter int NUM_CHANNELS = 2
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_source_channel,
    input logic [epda_pkg::DIST_W-1:0]    i_distance,
    input logic                           i_report_valid,
    input logic [epda_pkg::DIST_W-1:0]    i_report_distance,
    input logic                           i_trigger_next,
    input logic                           i_cfg_valid,
    input logic                           i_cfg_ready,
    input logic [epda_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [epda_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam logic [2:0] NCH = 3'(NUM_CHANNELS);

    logic       r_avg_en;
    logic [2:0] w_next;

    // track the averaging mode from the configuration transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_en <= epda_pkg::RST_AVG_EN;
        end else if (i_cfg_valid && i_cfg_ready &&
                     (i_cfg_index == epda_pkg::REG_AVG_EN)) begin
            r_avg_en <= i_cfg_data[0];
        end
    end

    always_comb begin
        w_next = 3'(i_source_channel) + 3'd1;
        if (w_next >= NCH) begin
            w_next = w_next - NCH;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_source_channel, i_distance, i_report_valid,
                 i_report_distance, i_trigger_next}))
        else $error("result changed while stalled");

    a_no_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_report_valid |-> i_report_distance == '0)
        else $error("report distance without a due report");

    a_trigger_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_trigger_next == w_next[0])
        else $error("wrong sensor named to fire next");

    a_direct_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !r_avg_en |-> i_report_valid &&
        (i_report_distance == i_distance))
        else $error("unaveraged result not reported directly");

endmodule

bind echo_pulse_distance_averager epda_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_epda_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_source_channel  (o_out.source_channel),
    .i_distance        (o_out.distance),
    .i_report_valid    (o_out.report_valid),
    .i_report_distance (o_out.report_distance),
    .i_trigger_next    (o_out.trigger_next),
    .i_cfg_valid       (i_cfg.valid),
    .i_cfg_ready       (i_cfg.ready),
    .i_cfg_index       (i_cfg.index),
    .i_cfg_data        (i_cfg.data)
);
